// File: rtl/gds_pkg.sv
// ----------------------------------------------------------------------------
// gds_pkg: shared constants and types of the greedy distance subsampler
// Sizes of the store, the cell row, the register map and the token structs.
// ----------------------------------------------------------------------------
package gds_pkg;

	// Sizing of the descriptor stream and the vector store.
	localparam int MAX_DIM      = 64;
	localparam int MAX_KEPT     = 1024;
	localparam int ELEMENT_BITS = 16;

	// Field widths fixed by the result format.
	localparam int DIST_W    = 40;
	localparam int INDEX_W   = 24;
	localparam int COUNT_W   = 11;
	localparam int CFG_LEN_W = 7;

	// Number of distance cells in the row; each cell owns one bank of the store.
	localparam int LANES  = 8;
	localparam int LANE_W = $clog2(LANES);
	localparam int LIVE_W = LANE_W + 1;

	localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int LEN_W   = $clog2(MAX_DIM + 1);
	localparam int KEPT_W  = $clog2(MAX_KEPT + 1);
	localparam int GROUPS  = (MAX_KEPT + LANES - 1) / LANES;
	localparam int GRP_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int BANK_AW = GRP_W + DIM_W;
	localparam int BANK_DEPTH = 2 ** BANK_AW;
	localparam int CUR_DEPTH  = 2 ** DIM_W;

	// Cycles after the last comparison token until every cell has reported.
	localparam int DRAIN_CYCLES = LANES + 4;
	localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

	// Register port.
	localparam int APB_AW = 4;
	localparam int APB_DW = 64;
	localparam logic REG_MIN_DIST = 1'b0;
	localparam logic REG_VEC_LEN  = 1'b1;
	localparam logic [CFG_LEN_W-1:0] VEC_LEN_RESET = 7'd64;

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_COMPARE,
		ST_DRAIN,
		ST_DECIDE,
		ST_COPY,
		ST_REPORT
	} state_t;

	// One element of the candidate vector travelling down the cell row.
	typedef struct packed {
		logic                    valid;
		logic                    first;
		logic                    last;
		logic [LIVE_W-1:0]       live;
		logic [BANK_AW-1:0]      addr;
		logic [ELEMENT_BITS-1:0] elem;
	} tok_t;

	// Store write, broadcast to all cells; only the addressed bank takes it.
	typedef struct packed {
		logic                    en;
		logic [LANE_W-1:0]       lane;
		logic [BANK_AW-1:0]      addr;
		logic [ELEMENT_BITS-1:0] data;
	} wr_t;

endpackage

// File: rtl/gds_in_if.sv
// ----------------------------------------------------------------------------
// gds_in_if: descriptor element stream
// Valid/ready channel carrying one signed descriptor element per transfer.
// ----------------------------------------------------------------------------
interface gds_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [gds_pkg::ELEMENT_BITS-1:0] descriptor_element;

	modport source (output valid, output descriptor_element, input ready);
	modport sink (input valid, input descriptor_element, output ready);
endinterface

// File: rtl/gds_out_if.sv
// ----------------------------------------------------------------------------
// gds_out_if: decision result stream
// Valid/ready channel carrying one keep/reject decision per transfer.
// ----------------------------------------------------------------------------
interface gds_out_if;
	logic                          valid;
	logic                          ready;
	logic [gds_pkg::INDEX_W-1:0]   vector_index;
	logic                          selected;
	logic                          store_overflow;
	logic [gds_pkg::COUNT_W-1:0]   kept_count;

	modport source (output valid, output vector_index, output selected,
		output store_overflow, output kept_count, input ready);
	modport sink (input valid, input vector_index, input selected,
		input store_overflow, input kept_count, output ready);
endinterface

// File: rtl/gds_ram.sv
// ----------------------------------------------------------------------------
// gds_ram: generic single-port-write, single-port-read memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gds_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/gds_cell.sv
// ----------------------------------------------------------------------------
// gds_cell: one distance cell of the comparison row
// Holds one bank of kept vectors and accumulates a saturating squared
// distance as candidate elements pass through on their way to the next cell.
// ----------------------------------------------------------------------------
module gds_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [gds_pkg::LANE_W-1:0]    lane_id,
	input  logic [gds_pkg::DIST_W-1:0]    threshold,
	input  gds_pkg::tok_t                 tok_in,
	output gds_pkg::tok_t                 tok_out,
	input  gds_pkg::wr_t                  wr,
	output logic                          near
);
	import gds_pkg::*;

	localparam int EB = ELEMENT_BITS;

	tok_t                  tok_s1;
	logic [EB-1:0]         kept_elem;
	logic signed [EB:0]    diff;
	logic [EB-1:0]         mag;
	logic                  live_s1;
	logic [2*EB-1:0]       sq_s2;
	logic                  v_s2, first_s2, last_s2, live_s2;
	logic [DIST_W-1:0]     acc_q, base, acc_next;
	logic [DIST_W:0]       sum;
	logic                  near_q;

	gds_ram #(.WIDTH(EB), .DEPTH(BANK_DEPTH)) u_bank (
		.clk   (clk),
		.we    (wr.en && (wr.lane == lane_id)),
		.waddr (wr.addr),
		.wdata (wr.data),
		.raddr (tok_in.addr),
		.rdata (kept_elem)
	);

	// The bank read issued with tok_in lines up with tok_s1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1 <= tok_in;
		end
	end

	assign tok_out = tok_s1;

	always_comb begin
		diff = $signed({tok_s1.elem[EB-1], tok_s1.elem}) - $signed({kept_elem[EB-1], kept_elem});
		mag = diff[EB] ? EB'(-diff) : EB'(diff);
		live_s1 = {1'b0, lane_id} < tok_s1.live;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= tok_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		sq_s2    <= mag * mag;
		first_s2 <= tok_s1.first;
		last_s2  <= tok_s1.last;
		live_s2  <= live_s1;
	end

	// Saturating accumulate; a saturated sum can never fall below the threshold.
	always_comb begin
		base = first_s2 ? '0 : acc_q;
		sum = {1'b0, base} + (DIST_W + 1)'(sq_s2);
		acc_next = sum[DIST_W] ? '1 : sum[DIST_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			acc_q <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= 1'b0;
		end else begin
			near_q <= v_s2 && last_s2 && live_s2 && (acc_next < threshold);
		end
	end

	assign near = near_q;

endmodule

// File: rtl/greedy_distance_subsampler.sv
// ----------------------------------------------------------------------------
// greedy_distance_subsampler: minimum-distance vector subsampling
// Sequence: a vector of length L is accepted, then, if the store is not empty, it is
//   compared with the K kept vectors in groups of eight, followed by a decision,
//   the copy of all 64 positions of a kept vector, and a result.
// Throughput: one element per cycle while a vector streams in; the comparison,
//   paced by one bank read per cell per cycle across 8 cells, sets the rest.
// Reset: asynchronous, active low; clears counters and control, store undefined.
// ----------------------------------------------------------------------------
module greedy_distance_subsampler (
	input  logic                          clk,
	input  logic                          arst_n,
	gds_in_if.sink                        in_stream,
	gds_out_if.source                     out_stream,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gds_pkg::APB_AW-1:0]    paddr,
	input  logic [gds_pkg::APB_DW-1:0]    pwdata,
	output logic [gds_pkg::APB_DW-1:0]    prdata,
	output logic                          pready
);
	import gds_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers. Register index is paddr[3], as each
	// register occupies an 8-byte slot.
	// ------------------------------------------------------------------
	logic [DIST_W-1:0]    min_dist_q;
	logic [CFG_LEN_W-1:0] vec_len_q;
	logic                 cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q <= '0;
			vec_len_q  <= VEC_LEN_RESET;
		end else if (cfg_we) begin
			case (paddr[3])
				REG_MIN_DIST: min_dist_q <= pwdata[DIST_W-1:0];
				REG_VEC_LEN:  vec_len_q  <= pwdata[CFG_LEN_W-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			REG_MIN_DIST: prdata = APB_DW'(min_dist_q);
			REG_VEC_LEN:  prdata = APB_DW'(vec_len_q);
			default:      prdata = '0;
		endcase
	end

	// Length in use: zero acts as one, anything past the maximum is clamped.
	logic [LEN_W-1:0] len_eff;

	always_comb begin
		if (vec_len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (int'(vec_len_q) > MAX_DIM) begin
			len_eff = LEN_W'(MAX_DIM);
		end else begin
			len_eff = LEN_W'(vec_len_q);
		end
	end

	// ------------------------------------------------------------------
	// Sequencer state.
	// ------------------------------------------------------------------
	state_t               state_q, state_d;
	logic [LEN_W-1:0]     len_q;
	logic [DIM_W-1:0]     pos_q, d_q;
	logic [GRP_W-1:0]     g_q, last_grp, kept_grp;
	logic [DRAIN_W-1:0]   drain_q;
	logic [KEPT_W-1:0]    kept_q, kept_next, rem;
	logic [LIVE_W-1:0]    live_lanes;
	logic [INDEX_W-1:0]   vcount_q;
	logic                 reject_q, keep_q, ovf_q;
	logic                 out_valid_q;
	logic                 in_fire, completes, cmp_last_d, copy_last, report_go, room;
	logic                 any_near;

	// Current vector buffer: written as elements arrive, read for compare and copy.
	logic [ELEMENT_BITS-1:0] cur_rdata;

	gds_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(CUR_DEPTH)) u_cur (
		.clk   (clk),
		.we    (in_fire),
		.waddr (pos_q),
		.wdata (in_stream.descriptor_element),
		.raddr (d_q),
		.rdata (cur_rdata)
	);

	assign in_fire    = in_stream.valid && in_stream.ready;
	assign completes  = (LEN_W'(pos_q) + LEN_W'(1)) >= len_eff;
	assign cmp_last_d = (LEN_W'(d_q) + LEN_W'(1)) == len_q;
	assign copy_last  = d_q == DIM_W'(MAX_DIM - 1);
	assign report_go  = !out_valid_q || out_stream.ready;
	assign room       = kept_q < KEPT_W'(MAX_KEPT);
	assign kept_next  = kept_q + KEPT_W'(keep_q && !ovf_q);

	// Groups of eight kept vectors are compared in one pass of the row; the
	// last group may be only partly filled.
	always_comb begin
		last_grp = GRP_W'((kept_q - KEPT_W'(1)) >> LANE_W);
		kept_grp = GRP_W'(kept_q >> LANE_W);
		rem = kept_q - (KEPT_W'(g_q) << LANE_W);
		live_lanes = (rem >= KEPT_W'(LANES)) ? LIVE_W'(LANES) : LIVE_W'(rem);
	end

	// Next state and handshake outputs.
	always_comb begin
		state_d = state_q;
		in_stream.ready = 1'b0;
		case (state_q)
			ST_COLLECT: begin
				in_stream.ready = 1'b1;
				if (in_fire && completes) begin
					state_d = (kept_q == '0) ? ST_DECIDE : ST_COMPARE;
				end
			end
			ST_COMPARE: begin
				if (cmp_last_d && (g_q == last_grp)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_q == DRAIN_W'(DRAIN_CYCLES - 1)) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = (!reject_q && room) ? ST_COPY : ST_REPORT;
			end
			ST_COPY: begin
				if (copy_last) begin
					state_d = ST_REPORT;
				end
			end
			ST_REPORT: begin
				if (report_go) begin
					state_d = ST_COLLECT;
				end
			end
			default: state_d = ST_COLLECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Counters and decision flags.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			pos_q       <= '0;
			d_q         <= '0;
			g_q         <= '0;
			drain_q     <= '0;
			kept_q      <= '0;
			vcount_q    <= '0;
			reject_q    <= 1'b0;
			keep_q      <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// A new decision replaces the one leaving in the same cycle.
			if ((state_q == ST_REPORT) && report_go) begin
				out_valid_q <= 1'b1;
			end else if (out_stream.ready) begin
				out_valid_q <= 1'b0;
			end
			// Any cell that finds a kept vector too close rejects the candidate.
			if ((state_q == ST_COMPARE) || (state_q == ST_DRAIN)) begin
				reject_q <= reject_q | any_near;
			end
			case (state_q)
				ST_COLLECT: begin
					if (in_fire) begin
						if (completes) begin
							pos_q    <= '0;
							len_q    <= len_eff;
							d_q      <= '0;
							g_q      <= '0;
							reject_q <= 1'b0;
						end else begin
							pos_q <= pos_q + DIM_W'(1);
						end
					end
				end
				ST_COMPARE: begin
					if (cmp_last_d) begin
						d_q     <= '0;
						g_q     <= g_q + GRP_W'(1);
						drain_q <= '0;
					end else begin
						d_q <= d_q + DIM_W'(1);
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + DRAIN_W'(1);
				end
				ST_DECIDE: begin
					keep_q <= !reject_q;
					ovf_q  <= !reject_q && !room;
					d_q    <= '0;
				end
				ST_COPY: begin
					d_q <= copy_last ? '0 : d_q + DIM_W'(1);
				end
				ST_REPORT: begin
					if (report_go) begin
						kept_q      <= kept_next;
						vcount_q    <= vcount_q + INDEX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Result register: holds a finished decision while the next vector streams in.
	logic [INDEX_W-1:0] out_index_q;
	logic               out_sel_q, out_ovf_q;
	logic [COUNT_W-1:0] out_count_q;

	always_ff @(posedge clk) begin
		if ((state_q == ST_REPORT) && report_go) begin
			out_index_q <= vcount_q;
			out_sel_q   <= keep_q;
			out_ovf_q   <= ovf_q;
			out_count_q <= COUNT_W'(kept_next);
		end
	end

	assign out_stream.valid          = out_valid_q;
	assign out_stream.vector_index   = out_index_q;
	assign out_stream.selected       = out_sel_q;
	assign out_stream.store_overflow = out_ovf_q;
	assign out_stream.kept_count     = out_count_q;

	// ------------------------------------------------------------------
	// Cell row. The buffer read is registered, so the token control is
	// registered alongside it and the element joins from the read data.
	// The copy of a kept vector is staged the same way.
	// ------------------------------------------------------------------
	logic               tok_v_s1, tok_first_s1, tok_last_s1;
	logic [LIVE_W-1:0]  tok_live_s1;
	logic [BANK_AW-1:0] tok_addr_s1, wr_addr_s1;
	logic               wr_en_s1;
	logic [LANE_W-1:0]  wr_lane_s1;
	tok_t               tok_chain [LANES+1];
	wr_t                wr_bus;
	logic [LANES-1:0]   near;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_v_s1 <= 1'b0;
			wr_en_s1 <= 1'b0;
		end else begin
			tok_v_s1 <= state_q == ST_COMPARE;
			wr_en_s1 <= state_q == ST_COPY;
		end
	end

	always_ff @(posedge clk) begin
		tok_first_s1 <= d_q == '0;
		tok_last_s1  <= cmp_last_d;
		tok_live_s1  <= live_lanes;
		tok_addr_s1  <= {g_q, d_q};
		wr_lane_s1   <= kept_q[LANE_W-1:0];
		wr_addr_s1   <= {kept_grp, d_q};
	end

	always_comb begin
		tok_chain[0] = '{valid: tok_v_s1, first: tok_first_s1, last: tok_last_s1,
			live: tok_live_s1, addr: tok_addr_s1, elem: cur_rdata};
		wr_bus = '{en: wr_en_s1, lane: wr_lane_s1, addr: wr_addr_s1, data: cur_rdata};
	end

	for (genvar i = 0; i < LANES; i++) begin : g_cell
		gds_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.lane_id   (LANE_W'(i)),
			.threshold (min_dist_q),
			.tok_in    (tok_chain[i]),
			.tok_out   (tok_chain[i+1]),
			.wr        (wr_bus),
			.near      (near[i])
		);
	end

	assign any_near = |near;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= KEPT_W'(MAX_KEPT))
		else $error("kept count beyond store size");

	a_ovf_needs_sel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ovf_q |-> out_sel_q)
		else $error("overflow reported on a rejected vector");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ovf_q |-> out_count_q == COUNT_W'(MAX_KEPT))
		else $error("overflow reported while store not full");

	a_write_after_copy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en_s1 |-> $past(state_q == ST_COPY))
		else $error("store write outside copy phase");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the greedy distance subsampler
// Streams descriptor elements through the input channel, programs the
// threshold and vector length over the register port, and checks every
// keep/reject decision against an in-bench model of the vector store.
// ----------------------------------------------------------------------------
module tb;
	import gds_pkg::*;

	localparam int     RESET_CYCLES  = 11;
	localparam longint CYCLE_LIMIT   = 4_000_000;
	localparam int     RANDOM_ITEMS  = 900;
	localparam int     PHASE_ITEMS   = 100;
	localparam int     CENTER_COUNT  = 4;
	// Quiet cycles before a register write once all decisions are in.
	localparam int     IDLE_SETTLE   = 16;
	// Worst comparison pass over a full store at full length, plus margin.
	localparam int     END_SETTLE    = (MAX_KEPT + LANES - 1) / LANES * MAX_DIM + 100;
	localparam int     LEN_FIELD_MAX = 2 ** CFG_LEN_W - 1;

	localparam logic [DIST_W-1:0] DIST_SAT = '1;
	localparam logic [APB_AW-1:0] ADDR_MIN_DIST = {REG_MIN_DIST, 3'b000};
	localparam logic [APB_AW-1:0] ADDR_VEC_LEN  = {REG_VEC_LEN, 3'b000};

	typedef logic signed [ELEMENT_BITS-1:0] elem_t;

	localparam elem_t ELEM_MIN = {1'b1, {(ELEMENT_BITS-1){1'b0}}};
	localparam elem_t ELEM_MAX = {1'b0, {(ELEMENT_BITS-1){1'b1}}};

	typedef struct packed {
		logic [INDEX_W-1:0] vector_index;
		logic               selected;
		logic               store_overflow;
		logic [COUNT_W-1:0] kept_count;
	} decision_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	gds_in_if  in_if ();
	gds_out_if out_if ();

	greedy_distance_subsampler uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_stream  (in_if),
		.out_stream (out_if),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	// ------------------------------------------------------------------
	// Model state. The bench keeps its own copy of the registers, the
	// vector under assembly and the store, updated on each accepted
	// element transfer and each register write.
	// ------------------------------------------------------------------
	logic [DIST_W-1:0]    min_dist_sq;
	logic [CFG_LEN_W-1:0] len_setting;
	elem_t                cand_elems [MAX_DIM];
	elem_t                kept_bank [MAX_KEPT][MAX_DIM];
	int                   kept_n;
	int                   elem_pos;
	logic [INDEX_W-1:0]   next_index;

	// Decisions predicted but not yet seen on the result channel, oldest first.
	decision_t pending_decisions [$];

	int     mismatches  = 0;
	longint cycle_count = 0;
	// When set, both channel sides run without any idle or stall cycles.
	logic   no_idle     = 1'b0;

	elem_t centers [CENTER_COUNT][MAX_DIM];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The register value is clamped to 1..MAX_DIM when it is used.
	function automatic int active_length();
		if (len_setting == 0)
			return 1;
		if (len_setting > MAX_DIM)
			return MAX_DIM;
		return int'(len_setting);
	endfunction

	// Squared Euclidean distance of the assembled vector to one stored vector,
	// over the first len elements, saturating at the top of the 40-bit range.
	function automatic logic [DIST_W-1:0] sq_distance(input int slot, input int len);
		longint acc;
		longint diff;
		longint sq;
		int     d;
		acc = 0;
		for (d = 0; d < len; d++) begin
			diff = longint'(cand_elems[d]) - longint'(kept_bank[slot][d]);
			sq   = diff * diff;
			if (sq > longint'(DIST_SAT) - acc)
				acc = longint'(DIST_SAT);
			else
				acc += sq;
		end
		return acc[DIST_W-1:0];
	endfunction

	// Takes one accepted element. When it completes a vector, the vector is compared
	// with the stored ones until one is too close, and the resulting decision is queued.
	task automatic absorb_element(input elem_t e);
		int        len;
		int        pos;
		int        m;
		int        d;
		logic      keep;
		logic      ovf;
		decision_t dec;
		len = active_length();
		pos = elem_pos;
		if (pos >= MAX_DIM)
			pos = MAX_DIM - 1;
		cand_elems[pos] = e;
		if (pos + 1 < len) begin
			elem_pos = pos + 1;
		end else begin
			elem_pos = 0;
			keep     = 1'b1;
			ovf      = 1'b0;
			for (m = 0; m < kept_n && keep; m++) begin
				if (sq_distance(m, len) < min_dist_sq)
					keep = 1'b0;
			end
			if (keep) begin
				if (kept_n >= MAX_KEPT) begin
					ovf = 1'b1;
				end else begin
					// The whole vector is stored, stale positions included.
					for (d = 0; d < MAX_DIM; d++)
						kept_bank[kept_n][d] = cand_elems[d];
					kept_n++;
				end
			end
			dec.vector_index   = next_index;
			dec.selected       = keep;
			dec.store_overflow = ovf;
			dec.kept_count     = kept_n[COUNT_W-1:0];
			pending_decisions.push_back(dec);
			next_index = next_index + 1'b1;
		end
	endtask

	// ------------------------------------------------------------------
	// Result checker. Sampling happens at the rising edge, before the
	// block's own updates land. A result transfer is checked before the
	// element transfer of the same edge is modeled, so a decision queued
	// at this edge can never be matched against an older result.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : decision_checker
		decision_t want;
		if (arst_n) begin
			if (out_if.valid && out_if.ready) begin
				if (pending_decisions.size() == 0) begin
					$error("unexpected result: vector_index %0d", out_if.vector_index);
					mismatches++;
				end else begin
					want = pending_decisions.pop_front();
					if (out_if.vector_index !== want.vector_index) begin
						$error("vector_index: expected %0d, actual %0d",
							want.vector_index, out_if.vector_index);
						mismatches++;
					end
					if (out_if.selected !== want.selected) begin
						$error("selected: expected %0d, actual %0d",
							want.selected, out_if.selected);
						mismatches++;
					end
					if (out_if.store_overflow !== want.store_overflow) begin
						$error("store_overflow: expected %0d, actual %0d",
							want.store_overflow, out_if.store_overflow);
						mismatches++;
					end
					if (out_if.kept_count !== want.kept_count) begin
						$error("kept_count: expected %0d, actual %0d",
							want.kept_count, out_if.kept_count);
						mismatches++;
					end
				end
			end
			if (in_if.valid && in_if.ready)
				absorb_element(in_if.descriptor_element);
		end
	end

	// Watchdog: a hung block or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Result side. Outside no-idle stretches, ready waits low until a
	// result shows up and then rises after a random delay, so
	// back-pressure lands on the block while it holds a decision.
	// ------------------------------------------------------------------
	initial begin : result_sink
		int stall;
		out_if.ready = 1'b0;
		forever begin
			if (no_idle) begin
				@(negedge clk);
				out_if.ready <= 1'b1;
				do @(posedge clk); while (!out_if.valid);
			end else begin
				@(negedge clk);
				out_if.ready <= 1'b0;
				do @(posedge clk); while (!out_if.valid);
				stall = $urandom_range(0, 9);
				repeat (stall) @(negedge clk);
				@(negedge clk);
				out_if.ready <= 1'b1;
				do @(posedge clk); while (!out_if.valid);
			end
		end
	end

	// Offers one element after a random gap and returns on its transfer.
	// Valid stays high afterwards, so calls with a zero gap stream back to back.
	task automatic send_element(input elem_t e);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		repeat (gap) begin
			@(negedge clk);
			in_if.valid <= 1'b0;
		end
		@(negedge clk);
		in_if.valid              <= 1'b1;
		in_if.descriptor_element <= e;
		do @(posedge clk); while (!in_if.ready);
	endtask

	// Register write: setup cycle, then access cycle until pready.
	task automatic write_register(input logic [APB_AW-1:0] addr,
			input logic [APB_DW-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (addr)
			ADDR_MIN_DIST: min_dist_sq = data[DIST_W-1:0];
			ADDR_VEC_LEN:  len_setting = data[CFG_LEN_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Stops the stream, waits for every queued decision and then lets the
	// block sit idle as long as the caller asks, so that nothing is still in flight.
	task automatic settle_block(input int extra);
		@(negedge clk);
		in_if.valid <= 1'b0;
		while (pending_decisions.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------

	// One full vector at the reset length and the reset threshold. It must be
	// kept, and it writes every position of the vector buffer, so no later
	// comparison can touch an element that was never written.
	task automatic test_reset_defaults();
		int    i;
		elem_t e;
		for (i = 0; i < MAX_DIM; i++) begin
			case (i % 6)
				0:       e = ELEM_MIN;
				1:       e = ELEM_MAX;
				2:       e = '0;
				3:       e = -1;
				4:       e = 1;
				default: e = elem_t'($urandom);
			endcase
			send_element(e);
		end
		settle_block(IDLE_SETTLE);
	endtask

	// The largest threshold rejects everything once the store holds a vector;
	// a zero threshold keeps even an exact duplicate.
	task automatic test_threshold_extremes();
		write_register(ADDR_VEC_LEN, 2);
		write_register(ADDR_MIN_DIST, APB_DW'(DIST_SAT));
		send_element(5);
		send_element(-5);
		settle_block(IDLE_SETTLE);
		write_register(ADDR_MIN_DIST, 0);
		send_element(5);
		send_element(-5);
		send_element(5);
		send_element(-5);
		settle_block(IDLE_SETTLE);
	endtask

	// Single-element vectors far from anything stored so far. A distance equal
	// to the threshold keeps the vector; one below it rejects.
	task automatic test_threshold_boundary();
		write_register(ADDR_VEC_LEN, 1);
		write_register(ADDR_MIN_DIST, 0);
		send_element(1000);
		settle_block(IDLE_SETTLE);
		write_register(ADDR_MIN_DIST, 9);
		send_element(1003);
		settle_block(IDLE_SETTLE);
		write_register(ADDR_MIN_DIST, 10);
		send_element(1002);
		settle_block(IDLE_SETTLE);
		write_register(ADDR_MIN_DIST, 1);
		send_element(1000);
		settle_block(IDLE_SETTLE);
	endtask

	// A length of zero behaves as a length of one.
	task automatic test_length_zero();
		write_register(ADDR_VEC_LEN, 0);
		write_register(ADDR_MIN_DIST, 0);
		send_element(elem_t'($urandom));
		send_element(elem_t'($urandom));
		settle_block(IDLE_SETTLE);
	endtask

	// Shrinking the length past the current position completes the vector on
	// the next element; growing it stretches the vector under assembly.
	task automatic test_length_change_mid_vector();
		write_register(ADDR_VEC_LEN, 5);
		send_element(ELEM_MAX);
		send_element(ELEM_MIN);
		send_element(7);
		settle_block(IDLE_SETTLE);
		write_register(ADDR_VEC_LEN, 2);
		send_element(-7);
		settle_block(IDLE_SETTLE);
		send_element(100);
		settle_block(IDLE_SETTLE);
		write_register(ADDR_VEC_LEN, 4);
		send_element(-100);
		send_element(ELEM_MIN);
		send_element(ELEM_MAX);
		settle_block(IDLE_SETTLE);
	endtask

	// ------------------------------------------------------------------
	// Random phases. Each phase picks a length and a threshold, then sends
	// vectors built as noisy copies of a few random centers, with the
	// noise scaled to the threshold so that both decisions are common.
	// About one burst in ten is a run of random elements of random count,
	// which also knocks the vector boundaries out of step.
	// ------------------------------------------------------------------
	task automatic test_random_vectors();
		int     sent;
		int     phase;
		int     n;
		int     k;
		int     c;
		int     d;
		int     len;
		int     raw_len;
		int     shift;
		int     noise;
		longint thr;
		elem_t  e;
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			no_idle = ($urandom_range(0, 4) == 0);
			// The first phase always uses a length above the maximum.
			case (phase == 0 ? 1 : $urandom_range(0, 19))
				0:       raw_len = 0;
				1:       raw_len = $urandom_range(MAX_DIM + 1, LEN_FIELD_MAX);
				2:       raw_len = MAX_DIM;
				3, 4:    raw_len = $urandom_range(17, MAX_DIM - 1);
				default: raw_len = $urandom_range(1, 16);
			endcase
			write_register(ADDR_VEC_LEN, APB_DW'(raw_len));
			len   = active_length();
			shift = $urandom_range(0, ELEMENT_BITS - 1);
			case ($urandom_range(0, 9))
				0:       thr = 0;
				1:       thr = longint'(DIST_SAT);
				default: thr = (longint'(len) << (2 * shift)) * $urandom_range(1, 6) / 3;
			endcase
			if (thr > longint'(DIST_SAT))
				thr = longint'(DIST_SAT);
			write_register(ADDR_MIN_DIST, thr);
			for (c = 0; c < CENTER_COUNT; c++)
				for (d = 0; d < MAX_DIM; d++)
					centers[c][d] = elem_t'($urandom);
			n = 0;
			while (n < PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0) begin
					k = $urandom_range(1, len);
					repeat (k) begin
						send_element(elem_t'($urandom));
						n++;
					end
				end else begin
					c = $urandom_range(0, CENTER_COUNT - 1);
					for (d = 0; d < len; d++) begin
						noise = int'($urandom_range(0, 2 * (1 << shift) - 1)) - (1 << shift);
						e     = elem_t'(centers[c][d] + noise);
						send_element(e);
						n++;
					end
				end
			end
			sent += n;
			settle_block(IDLE_SETTLE);
			phase++;
		end
		no_idle = 1'b0;
	endtask

	// Fills the store with single-element vectors at a zero threshold, then
	// shows that further keepers overflow, rejects do not, and the count holds.
	task automatic test_store_full();
		write_register(ADDR_VEC_LEN, 1);
		write_register(ADDR_MIN_DIST, 0);
		while (kept_n < MAX_KEPT)
			send_element(elem_t'($urandom));
		repeat (3) send_element(elem_t'($urandom));
		settle_block(IDLE_SETTLE);
		write_register(ADDR_MIN_DIST, APB_DW'(DIST_SAT));
		repeat (2) send_element(elem_t'($urandom));
		settle_block(IDLE_SETTLE);
		write_register(ADDR_MIN_DIST, 0);
		write_register(ADDR_VEC_LEN, 3);
		repeat (6) send_element(elem_t'($urandom));
		settle_block(IDLE_SETTLE);
	endtask

	// ------------------------------------------------------------------
	// Sequence: drive every input to a known value, hold reset, run the
	// tests in order, drain, and report.
	// ------------------------------------------------------------------
	initial begin
		arst_n                   = 1'b0;
		psel                     = 1'b0;
		penable                  = 1'b0;
		pwrite                   = 1'b0;
		paddr                    = '0;
		pwdata                   = '0;
		in_if.valid              = 1'b0;
		in_if.descriptor_element = '0;

		min_dist_sq = '0;
		len_setting = VEC_LEN_RESET;
		kept_n      = 0;
		elem_pos    = 0;
		next_index  = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_threshold_extremes();
		test_threshold_boundary();
		test_length_zero();
		test_length_change_mid_vector();
		test_random_vectors();
		test_store_full();

		// Long enough for a stray result from a full-store comparison to appear.
		settle_block(END_SETTLE);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: sim.f
rtl/gds_pkg.sv
rtl/gds_in_if.sv
rtl/gds_out_if.sv
rtl/gds_ram.sv
rtl/gds_cell.sv
rtl/greedy_distance_subsampler.sv
dv/tb.sv
